>>> src/heightmap_corner_vertex_average_macros.svh
// Assertion macros shared by the corner-vertex averager modules.
// Depends on clk_i and rst_ni being present in the module that expands them.
`ifndef HEIGHTMAP_CORNER_VERTEX_AVERAGE_MACROS_SVH
`define HEIGHTMAP_CORNER_VERTEX_AVERAGE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define HCVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define HCVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/hcva_pkg.sv
// Types, constants and helpers for the height-map corner-vertex averager.
// No dependencies; used by the result queue and the top level.
package hcva_pkg;

  localparam int COORD_W   = 9;
  localparam int HEIGHT_W  = 16;
  localparam int SPACING_W = 12;
  localparam int POS_X_W   = 20;
  localparam int POS_Y_W   = 21;
  localparam int POS_Z_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;
  localparam int IN_DATA_W = 16;
  localparam int OUT_RES_W = 2 * COORD_W + POS_X_W + POS_Y_W + POS_Z_W;
  localparam int OUT_DATA_W = ((OUT_RES_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RES_W;

  localparam int ROW_LIMIT = 256;

  localparam logic [COORD_W-1:0]   GRID_COLS_RST      = 9'd256;
  localparam logic [COORD_W-1:0]   GRID_ROWS_RST      = 9'd256;
  localparam logic [SPACING_W-1:0] VERTEX_SPACING_RST = 12'd205;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS      = 2'd0,
    CFG_GRID_ROWS      = 2'd1,
    CFG_VERTEX_SPACING = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_CELL  = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef struct packed {
    logic [COORD_W-1:0]        vertex_col;
    logic [COORD_W-1:0]        vertex_row;
    logic [POS_X_W-1:0]        pos_x;
    logic signed [POS_Y_W-1:0] pos_y;
    logic signed [POS_Z_W-1:0] pos_z;
    logic                      last_of_run;
  } result_t;

  // Push request into the result queue; two implies one.
  typedef struct packed {
    logic one;
    logic two;
  } push_t;

  // 2*avg - 1.0 in Q.16, wrapped to 17 bits: adding 2^16 flips the top bit.
  function automatic logic signed [POS_Z_W-1:0] z_from_avg(input logic [HEIGHT_W-1:0] avg);
    return {~avg[HEIGHT_W-1], avg[HEIGHT_W-2:0], 1'b0};
  endfunction

endpackage

>>> src/hcva_line_buf.sv
// Previous-row line buffer: one write port, two registered read ports.
// Reads that hit the same-cycle write return the new word. No package use.
module hcva_line_buf #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_a_q, rd_b_q, wdata_q;
  logic          byp_a_q, byp_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_a_q  <= mem[raddr_a_i];
    rd_b_q  <= mem[raddr_b_i];
    wdata_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
    end else begin
      byp_a_q <= we_i && (waddr_i == raddr_a_i);
      byp_b_q <= we_i && (waddr_i == raddr_b_i);
    end
  end

  assign rdata_a_o = byp_a_q ? wdata_q : rd_a_q;
  assign rdata_b_o = byp_b_q ? wdata_q : rd_b_q;

endmodule

>>> src/hcva_res_queue.sv
// Four-entry result queue that takes one or two words a cycle and gives one.
// Depends on hcva_pkg and the block's assertion macros.
`include "heightmap_corner_vertex_average_macros.svh"

module hcva_res_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hcva_pkg::push_t  push_i,
  input  hcva_pkg::result_t data0_i,
  input  hcva_pkg::result_t data1_i,
  output logic             room_o,
  output logic             valid_o,
  output hcva_pkg::result_t data_o,
  input  logic             ready_i
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  hcva_pkg::result_t entries_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // Keep room for a full pair so a row-end cell never overflows.
  assign room_o  = (cnt_q <= CW'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.one) + PW'(push_i.two);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    cnt_d    = cnt_q + CW'(push_i.one) + CW'(push_i.two) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.one) begin
      entries_q[wr_ptr_q] <= data0_i;
    end
    if (push_i.two) begin
      entries_q[wr_ptr_q + PW'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `HCVA_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "result queue overfilled")
  `HCVA_ASSERT(a_pair_push, push_i.two |-> push_i.one, "second word pushed without first")
  `HCVA_ASSERT_NEXT(a_cnt_track, push_i.one && !pop && cnt_q < CW'(DEPTH), cnt_q != '0, "pushed word lost")

endmodule

>>> src/heightmap_corner_vertex_average.sv
// Top level of the height-map corner-vertex averager.
// Depends on hcva_pkg, hcva_line_buf, hcva_res_queue and the assertion macros.
//
//  port group   dir  word contents
//  -----------  ---  -------------------------------------------------------
//  s_axis_*     in   height cell or bottom-row flush tick (kind in tuser)
//  m_axis_*     out  one vertex: col, row, x, y, z; tlast = last of the item
//  cfg_*        in   register write: grid_cols, grid_rows, vertex_spacing
//
// A word is accepted every cycle while the result queue has room for two.
// Each word is finished in the cycle it is accepted; its vertices go into the
// result queue, which feeds m_axis. A row-end cell yields two vertices, so a
// row of N cells gives N+1 vertices; the input drops ready to let the queue
// drain even when the output side is always ready. A stalled m_axis holds the
// queue; s_axis drops ready once two words would not fit. Reset clears the
// counters and the queue at once; the line buffer is not cleared.
`include "heightmap_corner_vertex_average_macros.svh"

module heightmap_corner_vertex_average #(
  parameter int MAX_COLS = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave side
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [hcva_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [15:0] height
  input  logic [0:0]                           s_axis_tuser,  // [0] kind
  // master side
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [8:0] vertex_col, [17:9] vertex_row, [37:18] pos_x, [58:38] pos_y,
  // [75:59] pos_z, [79:76] zero
  output logic [hcva_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,  // last_of_run
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [hcva_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hcva_pkg::CFG_W-1:0]           cfg_wdata_i
);

  localparam int LB_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW    = hcva_pkg::COORD_W;
  localparam int HW    = hcva_pkg::HEIGHT_W;
  localparam int SW    = hcva_pkg::SPACING_W;
  localparam int PW    = CW + SW;

  // Configuration registers
  logic [CW-1:0] grid_cols_q, grid_rows_q;
  logic [SW-1:0] spacing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= hcva_pkg::GRID_COLS_RST;
      grid_rows_q <= hcva_pkg::GRID_ROWS_RST;
      spacing_q   <= hcva_pkg::VERTEX_SPACING_RST;
    end else if (cfg_we_i) begin
      case (hcva_pkg::cfg_idx_e'(cfg_idx_i))
        hcva_pkg::CFG_GRID_COLS:      grid_cols_q <= cfg_wdata_i[CW-1:0];
        hcva_pkg::CFG_GRID_ROWS:      grid_rows_q <= cfg_wdata_i[CW-1:0];
        hcva_pkg::CFG_VERTEX_SPACING: spacing_q   <= cfg_wdata_i[SW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Clamp to the usable range: zero acts as one, large values saturate.
  logic [CW-1:0] cols_eff, rows_eff;

  always_comb begin
    if (grid_cols_q == '0) begin
      cols_eff = CW'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_q;
    end
    if (grid_rows_q == '0) begin
      rows_eff = CW'(1);
    end else if (32'(grid_rows_q) > hcva_pkg::ROW_LIMIT) begin
      rows_eff = CW'(hcva_pkg::ROW_LIMIT);
    end else begin
      rows_eff = grid_rows_q;
    end
  end

  // Scan state
  logic [CW-1:0] col_q, col_d, row_q, row_d, flush_q, flush_d;
  logic [HW-1:0] left_q, left_d, above_left_q, above_left_d;
  logic [HW-1:0] fl_left_q, fl_left_d;  // line entry west of the flush column

  logic [HW-1:0] height, up, up_flush;
  logic          in_fire, is_flush, frame_done, cell_go, tick_go;

  assign height     = s_axis_tdata[HW-1:0];
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign is_flush   = (hcva_pkg::kind_e'(s_axis_tuser[0]) == hcva_pkg::KIND_FLUSH);
  assign frame_done = (row_q >= rows_eff);
  // Cells past the last row and ticks before it are dropped silently.
  assign cell_go    = in_fire && !is_flush && !frame_done;
  assign tick_go    = in_fire && is_flush && frame_done;

  // Cell averaging: own cell, west, north, northwest.
  logic [CW:0]   col_inc;
  logic          row_end, has_w, has_n;
  logic [HW+1:0] cell_sum;
  logic [HW:0]   edge_sum;
  logic [HW-1:0] cell_avg, edge_avg;

  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign row_end = (col_inc >= {1'b0, cols_eff});
  assign has_w   = (col_q != '0);
  assign has_n   = (row_q != '0);

  always_comb begin
    cell_sum = (HW+2)'(height)
             + (has_w ? (HW+2)'(left_q) : '0)
             + (has_n ? (HW+2)'(up) : '0)
             + ((has_w && has_n) ? (HW+2)'(above_left_q) : '0);
    if (has_w && has_n) begin
      cell_avg = cell_sum[HW+1:2];
    end else if (has_w || has_n) begin
      cell_avg = cell_sum[HW:1];
    end else begin
      cell_avg = cell_sum[HW-1:0];
    end
    // East-edge vertex: own cell and north only.
    edge_sum = (HW+1)'(height) + (has_n ? (HW+1)'(up) : '0);
    edge_avg = has_n ? edge_sum[HW:1] : edge_sum[HW-1:0];
  end

  // Bottom-row averaging: west and east cells of the last row.
  logic          f_w, f_e;
  logic [HW:0]   flush_sum;
  logic [HW-1:0] flush_avg;

  assign f_w = (flush_q != '0);
  assign f_e = (flush_q < cols_eff);

  always_comb begin
    flush_sum = (f_w ? (HW+1)'(fl_left_q) : '0) + (f_e ? (HW+1)'(up_flush) : '0);
    flush_avg = (f_w && f_e) ? flush_sum[HW:1] : flush_sum[HW-1:0];
  end

  // Positions: one product for x, one for y; the east vertex adds one pitch.
  logic [CW-1:0] mul_col, mul_row;
  logic [PW-1:0] x_prod, x_next, y_prod;

  assign mul_col = is_flush ? flush_q : col_q;
  assign mul_row = is_flush ? rows_eff : row_q;
  assign x_prod  = PW'(mul_col) * PW'(spacing_q);
  assign x_next  = x_prod + PW'(spacing_q);
  assign y_prod  = PW'(mul_row) * PW'(spacing_q);

  hcva_pkg::result_t res0, res1;
  hcva_pkg::push_t   push;

  always_comb begin
    res0.vertex_col  = mul_col;
    res0.vertex_row  = mul_row;
    res0.pos_x       = x_prod[hcva_pkg::POS_X_W-1:0];
    res0.pos_y       = hcva_pkg::POS_Y_W'('0 - y_prod);
    res0.pos_z       = hcva_pkg::z_from_avg(is_flush ? flush_avg : cell_avg);
    res0.last_of_run = is_flush || !row_end;

    res1.vertex_col  = col_inc[CW-1:0];
    res1.vertex_row  = row_q;
    res1.pos_x       = x_next[hcva_pkg::POS_X_W-1:0];
    res1.pos_y       = hcva_pkg::POS_Y_W'('0 - y_prod);
    res1.pos_z       = hcva_pkg::z_from_avg(edge_avg);
    res1.last_of_run = 1'b1;

    push.one = cell_go || tick_go;
    push.two = cell_go && row_end;
  end

  // Next scan state
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    flush_d      = flush_q;
    left_d       = left_q;
    above_left_d = above_left_q;
    fl_left_d    = fl_left_q;
    if (cell_go) begin
      left_d       = height;
      above_left_d = up;
      if (row_end) begin
        col_d        = '0;
        row_d        = row_q + CW'(1);
        left_d       = '0;
        above_left_d = '0;
      end else begin
        col_d = col_inc[CW-1:0];
      end
      // Keep the flush west copy coherent with the line buffer.
      if (f_w && (col_q == flush_q - CW'(1))) begin
        fl_left_d = height;
      end
    end
    if (tick_go) begin
      if (!f_e) begin
        // Last bottom vertex: rewind for the next frame.
        flush_d      = '0;
        row_d        = '0;
        col_d        = '0;
        left_d       = '0;
        above_left_d = '0;
      end else begin
        flush_d   = flush_q + CW'(1);
        fl_left_d = up_flush;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      flush_q      <= '0;
      left_q       <= '0;
      above_left_q <= '0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      flush_q      <= flush_d;
      left_q       <= left_d;
      above_left_q <= above_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fl_left_q <= fl_left_d;
  end

  // Line buffer: prefetch the entries for the next column and flush column
  // so the data is waiting in the read registers when the next word lands.
  hcva_line_buf #(
    .DEPTH (MAX_COLS),
    .AW    (LB_AW),
    .DW    (HW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (cell_go),
    .waddr_i   (LB_AW'(col_q)),
    .wdata_i   (height),
    .raddr_a_i (LB_AW'(col_d)),
    .raddr_b_i (LB_AW'(flush_d)),
    .rdata_a_o (up),
    .rdata_b_o (up_flush)
  );

  hcva_pkg::result_t out_res;

  hcva_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (res0),
    .data1_i (res1),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_res),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{hcva_pkg::OUT_PAD_W{1'b0}}, out_res.pos_z, out_res.pos_y,
                         out_res.pos_x, out_res.vertex_row, out_res.vertex_col};
  assign m_axis_tlast = out_res.last_of_run;

  `HCVA_ASSERT_NEXT(a_row_wrap, cell_go && row_end, col_q == '0 && left_q == '0, "row end did not rewind column")
  `HCVA_ASSERT_NEXT(a_frame_wrap, tick_go && !f_e, row_q == '0 && flush_q == '0, "frame end did not rewind counters")
  `HCVA_ASSERT(a_exclusive, !(cell_go && tick_go), "cell and tick taken together")

endmodule
